// ----- hw/rtl/rbdq_pkg.sv -----
// ----------------------------------------------------------------------------
// rbdq_pkg
// Shared types and constants for the ring buffer deque checker.
// ----------------------------------------------------------------------------
package rbdq_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OCC_W    = 11;
  localparam int unsigned FUNC_W   = 2;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
  localparam logic signed [DATA_W-1:0] EMPTY_MARK = -32'sd1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_POP_FRONT  = 2'd1,
    FUNC_PUSH_BACK  = 2'd2,
    FUNC_POP_BACK   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic need_read;
  } dp_sts_t;

endpackage

// ----- hw/rtl/ring_buffer_deque_checker.sv -----
// ----------------------------------------------------------------------------
// ring_buffer_deque_checker
// Double-ended queue in a fixed ring store that checks popped values.
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_ready_o  func_i, value_i
//   out      output     out_valid_o/out_ready_i  pop_value_o, was_empty_o,
//                                                matched_o, all_matched_o,
//                                                push_dropped_o, occupancy_o
//
// A push or a pop on an empty queue steps through load, execute and respond; a
// pop that reads the store adds a read step for the single-port store's registered read.
// One command is in flight at a time; out_ready_i low holds the result and
// in_ready_o stays low until the result beat is taken.
// Reset clears pointers and count and sets the sticky match flag; the store needs
// no clearing since every entry is written before it is read.
// ----------------------------------------------------------------------------
module ring_buffer_deque_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic        [rbdq_pkg::FUNC_W-1:0]   func_i,
  input  logic signed [rbdq_pkg::DATA_W-1:0]   value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [rbdq_pkg::DATA_W-1:0]   pop_value_o,
  output logic                                 was_empty_o,
  output logic                                 matched_o,
  output logic                                 all_matched_o,
  output logic                                 push_dropped_o,
  output logic        [rbdq_pkg::OCC_W-1:0]    occupancy_o
);
  import rbdq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  rbdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rbdq_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .func_i         (func_i),
    .value_i        (value_i),
    .pop_value_o    (pop_value_o),
    .was_empty_o    (was_empty_o),
    .matched_o      (matched_o),
    .all_matched_o  (all_matched_o),
    .push_dropped_o (push_dropped_o),
    .occupancy_o    (occupancy_o)
  );

endmodule

// ----- hw/rtl/rbdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// rbdq_ctrl
// Command sequencer: load, execute, optional store read, then respond.
// ----------------------------------------------------------------------------
module rbdq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  rbdq_pkg::dp_sts_t sts_i,
  output rbdq_pkg::dp_cmd_t cmd_o
);
  import rbdq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.need_read ? ST_READ : ST_RESP;
      end
      ST_READ: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_RESP;
      end
      ST_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/rbdq_datapath.sv -----
// ----------------------------------------------------------------------------
// rbdq_datapath
// Ring store, front/back pointers, element count and result registers.
// ----------------------------------------------------------------------------
module rbdq_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rbdq_pkg::dp_cmd_t                    cmd_i,
  output rbdq_pkg::dp_sts_t                    sts_o,
  input  logic        [rbdq_pkg::FUNC_W-1:0]   func_i,
  input  logic signed [rbdq_pkg::DATA_W-1:0]   value_i,
  output logic signed [rbdq_pkg::DATA_W-1:0]   pop_value_o,
  output logic                                 was_empty_o,
  output logic                                 matched_o,
  output logic                                 all_matched_o,
  output logic                                 push_dropped_o,
  output logic        [rbdq_pkg::OCC_W-1:0]    occupancy_o
);
  import rbdq_pkg::*;

  logic signed [DATA_W-1:0] mem [CAPACITY];

  func_e                    func_q;
  logic signed [DATA_W-1:0] value_q;
  logic        [PTR_W-1:0]  front_q, front_d;
  logic        [PTR_W-1:0]  back_q, back_d;
  logic        [CNT_W-1:0]  count_q, count_d;
  logic                     all_ok_q, all_ok_d;
  logic signed [DATA_W-1:0] rdata_q;

  logic signed [DATA_W-1:0] pop_value_q;
  logic                     was_empty_q, matched_q, dropped_q;

  logic             is_pop, empty, full;
  logic [PTR_W-1:0] front_inc, front_dec, back_inc, back_dec;
  logic             mem_we, mem_re;
  logic [PTR_W-1:0] mem_addr;
  logic             rd_match;

  assign is_pop    = (func_q == FUNC_POP_FRONT) || (func_q == FUNC_POP_BACK);
  assign empty     = (count_q == '0);
  assign full      = (count_q >= CNT_FULL);
  assign front_inc = (front_q == PTR_LAST) ? '0 : front_q + 1'b1;
  assign front_dec = (front_q == '0) ? PTR_LAST : front_q - 1'b1;
  assign back_inc  = (back_q == PTR_LAST) ? '0 : back_q + 1'b1;
  assign back_dec  = (back_q == '0) ? PTR_LAST : back_q - 1'b1;
  assign rd_match  = (rdata_q == value_q);

  assign sts_o.need_read = is_pop && !empty;

  always_comb begin
    front_d  = front_q;
    back_d   = back_q;
    count_d  = count_q;
    all_ok_d = all_ok_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = front_q;
    if (cmd_i.exec) begin
      case (func_q)
        FUNC_PUSH_FRONT: begin
          if (!full) begin
            front_d  = front_dec;
            mem_addr = front_dec;
            mem_we   = 1'b1;
            count_d  = count_q + 1'b1;
          end
        end
        FUNC_PUSH_BACK: begin
          if (!full) begin
            back_d   = back_inc;
            mem_addr = back_q;
            mem_we   = 1'b1;
            count_d  = count_q + 1'b1;
          end
        end
        FUNC_POP_FRONT: begin
          if (empty) begin
            all_ok_d = all_ok_q & (value_q == EMPTY_MARK);
          end else begin
            mem_addr = front_q;
            mem_re   = 1'b1;
            front_d  = front_inc;
            count_d  = count_q - 1'b1;
          end
        end
        FUNC_POP_BACK: begin
          if (empty) begin
            all_ok_d = all_ok_q & (value_q == EMPTY_MARK);
          end else begin
            mem_addr = back_dec;
            mem_re   = 1'b1;
            back_d   = back_dec;
            count_d  = count_q - 1'b1;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.finish) begin
      all_ok_d = all_ok_q & rd_match;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= value_q;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      back_q   <= '0;
      count_q  <= '0;
      all_ok_q <= 1'b1;
    end else begin
      front_q  <= front_d;
      back_q   <= back_d;
      count_q  <= count_d;
      all_ok_q <= all_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_e'(func_i);
      value_q <= value_i;
    end
    if (cmd_i.exec) begin
      pop_value_q <= '0;
      was_empty_q <= is_pop && empty;
      matched_q   <= is_pop && empty ? (value_q == EMPTY_MARK) : 1'b1;
      dropped_q   <= !is_pop && full;
    end else if (cmd_i.finish) begin
      pop_value_q <= rdata_q;
      matched_q   <= rd_match;
    end
  end

  assign pop_value_o    = pop_value_q;
  assign was_empty_o    = was_empty_q;
  assign matched_o      = matched_q;
  assign push_dropped_o = dropped_q;
  assign all_matched_o  = all_ok_q;
  assign occupancy_o    = OCC_W'(count_q);

endmodule

// ----- sim/tb_ring_buffer_deque_checker.sv -----
// ----------------------------------------------------------------------------
// tb_ring_buffer_deque_checker
// Self-checking bench for the ring buffer deque checker. A short table of
// commands covers the empty pops, the value extremes, pointer wrap at both
// ends and the sticky mismatch flag. Random traffic follows: mixed commands,
// a fill past full that forces dropped pushes, a run of pops from the full
// store, and mixed commands near full.
// Every result beat is compared with the table's expected result or a cycle-free
// deque model, with random idling on both channels but in the last mixed run.
// ----------------------------------------------------------------------------
module tb_ring_buffer_deque_checker;
  timeunit 1ns;
  timeprecision 1ps;

  import rbdq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DIR_LEN     = 21;
  localparam int unsigned MIXED_LEN   = 100;
  localparam int unsigned DROP_LEN    = 24;
  localparam int unsigned TAIL_WAIT   = 8;

  typedef struct packed {
    logic signed [DATA_W-1:0] pop_value;
    logic                     was_empty;
    logic                     matched;
    logic                     all_matched;
    logic                     push_dropped;
    logic [OCC_W-1:0]         occupancy;
  } deque_res_t;

  typedef struct packed {
    func_e             func;
    logic [DATA_W-1:0] value;
    logic              known;
    deque_res_t        res;
  } dir_row_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  logic [FUNC_W-1:0]        func_i      = '0;
  logic signed [DATA_W-1:0] value_i     = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [DATA_W-1:0] pop_value_o;
  logic                     was_empty_o;
  logic                     matched_o;
  logic                     all_matched_o;
  logic                     push_dropped_o;
  logic [OCC_W-1:0]         occupancy_o;

  logic [DATA_W-1:0] ring_mem [CAPACITY];
  logic [PTR_W-1:0]  head_ptr  = '0;
  logic [PTR_W-1:0]  tail_ptr  = '0;
  logic [CNT_W-1:0]  held_cnt  = '0;
  logic              all_ok_q  = 1'b1;

  deque_res_t  pending_res_q [$];
  dir_row_t    dir_tab [DIR_LEN];
  int unsigned send_idle_pct = 8;
  int unsigned recv_idle_pct = 47;
  int unsigned cycle_cnt     = 0;
  int          err_cnt       = 0;

  ring_buffer_deque_checker uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pop_value_o    (pop_value_o),
    .was_empty_o    (was_empty_o),
    .matched_o      (matched_o),
    .all_matched_o  (all_matched_o),
    .push_dropped_o (push_dropped_o),
    .occupancy_o    (occupancy_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("FAIL ring_buffer_deque_checker");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_LAST : p - 1'b1;
  endfunction

  function automatic deque_res_t deque_apply(input func_e f, input logic [DATA_W-1:0] v);
    deque_res_t r;
    r = '0;
    r.matched = 1'b1;
    if (f == FUNC_PUSH_FRONT || f == FUNC_PUSH_BACK) begin
      if (held_cnt >= CNT_FULL) begin
        r.push_dropped = 1'b1;
      end else if (f == FUNC_PUSH_FRONT) begin
        head_ptr = ptr_prev(head_ptr);
        ring_mem[head_ptr] = v;
        held_cnt = held_cnt + 1'b1;
      end else begin
        ring_mem[tail_ptr] = v;
        tail_ptr = ptr_next(tail_ptr);
        held_cnt = held_cnt + 1'b1;
      end
    end else begin
      if (held_cnt == '0) begin
        r.was_empty = 1'b1;
        r.matched   = (v == EMPTY_MARK);
      end else begin
        if (f == FUNC_POP_FRONT) begin
          r.pop_value = ring_mem[head_ptr];
          head_ptr = ptr_next(head_ptr);
        end else begin
          tail_ptr = ptr_prev(tail_ptr);
          r.pop_value = ring_mem[tail_ptr];
        end
        held_cnt = held_cnt - 1'b1;
        r.matched = (r.pop_value == v);
      end
      all_ok_q = all_ok_q & r.matched;
    end
    r.all_matched = all_ok_q;
    r.occupancy   = OCC_W'(held_cnt);
    return r;
  endfunction

  task automatic issue_cmd(input func_e f, input logic [DATA_W-1:0] v,
                           input logic known, input deque_res_t known_res);
    deque_res_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    r = deque_apply(f, v);
    pending_res_q.push_back(known ? known_res : r);
  endtask

  task automatic issue_random(input int unsigned push_pct);
    func_e             f;
    logic [DATA_W-1:0] v;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < push_pct) begin
      f = ($urandom_range(0, 1) != 0) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
      case ($urandom_range(0, 9))
        0:       v = '0;
        1:       v = 32'h7fff_ffff;
        2:       v = 32'h8000_0000;
        3:       v = EMPTY_MARK;
        default: v = $urandom;
      endcase
    end else begin
      f = ($urandom_range(0, 1) != 0) ? FUNC_POP_FRONT : FUNC_POP_BACK;
      if (held_cnt == '0) begin
        v = (pick < 75) ? EMPTY_MARK : $urandom;
      end else if (pick < 85) begin
        v = (f == FUNC_POP_FRONT) ? ring_mem[head_ptr] : ring_mem[ptr_prev(tail_ptr)];
      end else if (pick < 95) begin
        v = $urandom;
      end else begin
        v = EMPTY_MARK;
      end
    end
    issue_cmd(f, v, 1'b0, '0);
  endtask

  task automatic wait_results;
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_res_q.size() != 0);
  endtask

  always @(posedge clk_i) begin
    deque_res_t got;
    deque_res_t want;
    if (out_valid_o && out_ready_i) begin
      got = '{pop_value_o, was_empty_o, matched_o, all_matched_o, push_dropped_o,
              occupancy_o};
      if (pending_res_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, got pop_value=%h", $time,
                 got.pop_value);
        err_cnt++;
      end else begin
        want = pending_res_q.pop_front();
        if (got !== want) begin
          $display({"%0t: mismatch exp pop_value=%h was_empty=%b matched=%b ",
                    "all_matched=%b push_dropped=%b occupancy=%0d"},
                   $time, want.pop_value, want.was_empty, want.matched,
                   want.all_matched, want.push_dropped, want.occupancy);
          $display({"%0t:          got pop_value=%h was_empty=%b matched=%b ",
                    "all_matched=%b push_dropped=%b occupancy=%0d"},
                   $time, got.pop_value, got.was_empty, got.matched,
                   got.all_matched, got.push_dropped, got.occupancy);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int unsigned drops;
    dir_tab[0]  = '{FUNC_POP_FRONT,  32'hffff_ffff, 1'b1, '{32'h0, 1'b1, 1'b1, 1'b1, 1'b0, 11'd0}};
    dir_tab[1]  = '{FUNC_POP_BACK,   32'hffff_ffff, 1'b1, '{32'h0, 1'b1, 1'b1, 1'b1, 1'b0, 11'd0}};
    dir_tab[2]  = '{FUNC_PUSH_FRONT, 32'h7fff_ffff, 1'b1, '{32'h0, 1'b0, 1'b1, 1'b1, 1'b0, 11'd1}};
    dir_tab[3]  = '{FUNC_PUSH_BACK,  32'h8000_0000, 1'b1, '{32'h0, 1'b0, 1'b1, 1'b1, 1'b0, 11'd2}};
    dir_tab[4]  = '{FUNC_PUSH_FRONT, 32'h0000_0000, 1'b1, '{32'h0, 1'b0, 1'b1, 1'b1, 1'b0, 11'd3}};
    dir_tab[5]  = '{FUNC_PUSH_BACK,  32'hffff_ffff, 1'b1, '{32'h0, 1'b0, 1'b1, 1'b1, 1'b0, 11'd4}};
    dir_tab[6]  = '{FUNC_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h0, 1'b0, 1'b1, 1'b1, 1'b0, 11'd3}};
    dir_tab[7]  = '{FUNC_POP_BACK,   32'hffff_ffff, 1'b1,
                    '{32'hffff_ffff, 1'b0, 1'b1, 1'b1, 1'b0, 11'd2}};
    dir_tab[8]  = '{FUNC_POP_BACK,   32'h8000_0000, 1'b1,
                    '{32'h8000_0000, 1'b0, 1'b1, 1'b1, 1'b0, 11'd1}};
    dir_tab[9]  = '{FUNC_POP_BACK,   32'h7fff_ffff, 1'b1,
                    '{32'h7fff_ffff, 1'b0, 1'b1, 1'b1, 1'b0, 11'd0}};
    dir_tab[10] = '{FUNC_POP_BACK,   32'hffff_ffff, 1'b1, '{32'h0, 1'b1, 1'b1, 1'b1, 1'b0, 11'd0}};
    dir_tab[11] = '{FUNC_PUSH_BACK,  32'h1234_5678, 1'b0, '0};
    dir_tab[12] = '{FUNC_PUSH_BACK,  32'h5a5a_5a5a, 1'b0, '0};
    dir_tab[13] = '{FUNC_PUSH_FRONT, 32'ha5a5_a5a5, 1'b0, '0};
    dir_tab[14] = '{FUNC_POP_FRONT,  32'ha5a5_a5a5, 1'b0, '0};
    dir_tab[15] = '{FUNC_POP_FRONT,  32'h1234_5678, 1'b0, '0};
    dir_tab[16] = '{FUNC_POP_BACK,   32'h5a5a_5a5a, 1'b0, '0};
    dir_tab[17] = '{FUNC_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h0, 1'b1, 1'b0, 1'b0, 1'b0, 11'd0}};
    dir_tab[18] = '{FUNC_PUSH_BACK,  32'hdead_beef, 1'b1, '{32'h0, 1'b0, 1'b1, 1'b0, 1'b0, 11'd1}};
    dir_tab[19] = '{FUNC_POP_FRONT,  32'h0000_0001, 1'b1,
                    '{32'hdead_beef, 1'b0, 1'b0, 1'b0, 1'b0, 11'd0}};
    dir_tab[20] = '{FUNC_POP_BACK,   32'hffff_ffff, 1'b1, '{32'h0, 1'b1, 1'b1, 1'b0, 1'b0, 11'd0}};

    wait (rst_ni);
    @(posedge clk_i);

    for (int i = 0; i < DIR_LEN; i++) begin
      issue_cmd(dir_tab[i].func, dir_tab[i].value, dir_tab[i].known, dir_tab[i].res);
    end
    repeat (MIXED_LEN) issue_random(50);
    wait_results();

    // fill past full, then pop a few back
    send_idle_pct = 47;
    recv_idle_pct = 8;
    drops = 0;
    while (drops < DROP_LEN) begin
      if (held_cnt == CNT_FULL) drops++;
      issue_random(98);
    end
    repeat (12) issue_random(0);
    wait_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (MIXED_LEN) issue_random(50);

    wait_results();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS ring_buffer_deque_checker");
    end else begin
      $display("FAIL ring_buffer_deque_checker");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/rbdq_pkg.sv
hw/rtl/rbdq_ctrl.sv
hw/rtl/rbdq_datapath.sv
hw/rtl/ring_buffer_deque_checker.sv
sim/tb_ring_buffer_deque_checker.sv
